// ===== sv/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the bit-level I2C master: word formats on
// both queues, command classes and the sequencer step codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // configuration register width and reset value
    localparam int unsigned HoldWidth = 16;
    localparam logic [HoldWidth-1:0] HoldReset = 16'd100;

    // bit slots in one byte transfer before the ack slot
    localparam logic [3:0] DataBits = 4'd8;

    // command classes, codes match the op field
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // sequencer step within the active command
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ONE  = 3'd1,
        ST_TWO  = 3'd2,
        ST_THREE = 3'd3,
        ST_FOUR = 3'd4
    } step_t;

    // input word as seen on the port
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } in_word_t;

    // classified word held between front and sequencer
    typedef struct packed {
        op_t        op;
        logic [7:0] shift_init;
        logic       send_nack;
        logic       sda_in;
    } cmd_word_t;

    // result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       acked;
    } res_word_t;

endpackage
`default_nettype wire

// ===== sv/i2c_bit_level_master.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A word accepted at the port is first registered in the command queue; the
// sequencer update and the result queue write for it then share one edge,
// once the result queue has room.
// Throughput: one word per cycle while the result side keeps up; the sequencer updates once per word.
// Reset: both queues empty, SCL and SDA released, hold length 100 ticks.
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level I2C master: front decode and command queue, tick sequencer, and
// a result queue toward the consumer.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire i2cm_pkg::in_word_t             item,
    output logic                                empty,
    input  wire logic                           pop,
    output i2cm_pkg::res_word_t                 result,
    input  wire logic                           wr_en,
    input  wire logic [i2cm_pkg::HoldWidth-1:0] wr_data
);
    import i2cm_pkg::*;

    cmd_word_t cmd_in;
    cmd_word_t cmd_out;
    logic      cmd_empty;
    logic      cmd_pop;
    res_word_t res_in;
    logic      res_full;
    logic      res_push;

    // word classification
    i2cm_front u_front (
        .item (item),
        .cmd  (cmd_in)
    );

    // command queue
    i2cm_queue #(
        .data_t (cmd_word_t)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    // bit sequencer
    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    i2cm_queue #(
        .data_t (res_word_t)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // every consumed command word yields exactly one result word
    a_word_balance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop == res_push)
        else $error("command pop and result push out of step");

    // a finishing tick leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> !result.busy_res)
        else $error("done reported while still busy");

    // no command word is taken while the result queue is full
    a_no_tick_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !cmd_pop)
        else $error("sequencer ran with result queue full");

endmodule
`default_nettype wire

// ===== sv/i2cm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry register queue; push and pop may happen in the same cycle, so a
// word per cycle passes through while the far side keeps up.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter type data_t = logic [7:0]
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire data_t wdata,
    output logic       full,
    input  wire logic  pop,
    output data_t      rdata,
    output logic       empty
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    data_t      slot0_reg;
    data_t      slot0_next;
    data_t      slot1_reg;
    data_t      slot1_next;
    logic       do_push;
    logic       do_pop;

    // handshake qualification
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot0_reg;

    // slot and fill count update
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = wdata;
                else
                    slot1_next = wdata;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = wdata;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = wdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
`default_nettype wire

// ===== sv/i2cm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Classifies incoming words: maps unused op codes to no command and loads
// the shift value only for byte writes.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  wire i2cm_pkg::in_word_t item,
    output i2cm_pkg::cmd_word_t     cmd
);
    import i2cm_pkg::*;

    op_t op_class;

    // op decode
    always_comb
    begin
        unique case (item.op)
            OP_START: op_class = OP_START;
            OP_STOP:  op_class = OP_STOP;
            OP_WRITE: op_class = OP_WRITE;
            OP_READ:  op_class = OP_READ;
            default:  op_class = OP_NONE;
        endcase
    end

    // classified word
    always_comb
    begin
        cmd.op         = op_class;
        cmd.shift_init = (op_class == OP_WRITE) ? item.tx_byte : 8'h00;
        cmd.send_nack  = item.send_nack;
        cmd.sda_in     = item.sda_in;
    end

endmodule
`default_nettype wire

// ===== sv/i2cm_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_seq
// Bit sequencer: one tick per command word, drives SCL/SDA through the pin
// steps of start, stop and byte transfers and emits one result word a tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [i2cm_pkg::HoldWidth-1:0] wr_data,
    input  wire i2cm_pkg::cmd_word_t           cmd,
    input  wire logic                          cmd_empty,
    output logic                               cmd_pop,
    input  wire logic                          res_full,
    output logic                               res_push,
    output i2cm_pkg::res_word_t                res
);
    import i2cm_pkg::*;

    logic [HoldWidth-1:0] hold_ticks_reg;
    logic [HoldWidth-1:0] hold_len;
    step_t                step_reg;
    step_t                step_next;
    op_t                  op_reg;
    op_t                  op_next;
    logic [3:0]           bit_reg;
    logic [3:0]           bit_next;
    logic [7:0]           shift_reg;
    logic [7:0]           shift_next;
    logic [HoldWidth-1:0] hold_reg;
    logic [HoldWidth-1:0] hold_next;
    logic                 nack_reg;
    logic                 nack_next;
    logic                 scl_reg;
    logic                 scl_next;
    logic                 sda_reg;
    logic                 sda_next;
    logic [7:0]           rx_reg;
    logic [7:0]           rx_next;
    logic                 ack_reg;
    logic                 ack_next;
    logic                 tick;
    logic                 enter;
    logic                 finish;
    logic                 done;

    // a tick runs when a word waits and the result queue has room
    assign tick     = !cmd_empty && !res_full;
    assign cmd_pop  = tick;
    assign res_push = tick;
    assign hold_len = (hold_ticks_reg == '0) ? {{(HoldWidth-1){1'b0}}, 1'b1} : hold_ticks_reg;

    // hold length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_ticks_reg <= HoldReset;
        else if (wr_en)
            hold_ticks_reg <= wr_data;
    end

    // next state: command load, hold countdown, step advance, shifting, ack and rx capture
    always_comb
    begin
        step_next  = step_reg;
        op_next    = op_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        nack_next  = nack_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        enter      = 1'b0;
        finish     = 1'b0;
        done       = 1'b0;
        if (tick)
        begin
            if (step_reg != ST_IDLE)
            begin
                if (hold_reg <= {{(HoldWidth-1){1'b0}}, 1'b1})
                begin
                    unique case (op_reg)
                        OP_START:
                        begin
                            unique case (step_reg)
                                ST_ONE:   step_next = ST_TWO;
                                ST_TWO:   step_next = ST_THREE;
                                ST_THREE: step_next = ST_FOUR;
                                default:  finish = 1'b1;
                            endcase
                        end
                        OP_STOP:
                        begin
                            unique case (step_reg)
                                ST_ONE:  step_next = ST_TWO;
                                ST_TWO:  step_next = ST_THREE;
                                default: finish = 1'b1;
                            endcase
                        end
                        OP_WRITE, OP_READ:
                        begin
                            unique case (step_reg)
                                ST_ONE:
                                begin
                                    step_next = ST_TWO;
                                end
                                ST_TWO:
                                begin
                                    if (bit_reg < DataBits)
                                    begin
                                        shift_next = {shift_reg[6:0],
                                                      (op_reg == OP_READ) && cmd.sda_in};
                                        bit_next   = bit_reg + 4'd1;
                                        step_next  = ST_ONE;
                                    end
                                    else
                                    begin
                                        if (op_reg == OP_WRITE)
                                            ack_next = !cmd.sda_in;
                                        step_next = ST_THREE;
                                    end
                                end
                                default:
                                begin
                                    finish = 1'b1;
                                end
                            endcase
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                    if (finish)
                    begin
                        if (op_reg == OP_READ)
                            rx_next = shift_reg;
                        step_next = ST_IDLE;
                        op_next   = OP_NONE;
                        bit_next  = 4'd0;
                        hold_next = '0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        enter = 1'b1;
                    end
                end
                else
                begin
                    hold_next = hold_reg - {{(HoldWidth-1){1'b0}}, 1'b1};
                end
            end
            else if (cmd.op != OP_NONE)
            begin
                op_next    = cmd.op;
                shift_next = cmd.shift_init;
                nack_next  = cmd.send_nack;
                bit_next   = 4'd0;
                step_next  = ST_ONE;
                enter      = 1'b1;
            end
            if (enter)
                hold_next = hold_len;
        end
    end

    // pin levels for a step being entered
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        if (enter)
        begin
            unique case (op_next)
                OP_START:
                begin
                    unique case (step_next)
                        ST_ONE:   sda_next = 1'b1;
                        ST_TWO:   scl_next = 1'b1;
                        ST_THREE: sda_next = 1'b0;
                        default:  scl_next = 1'b0;
                    endcase
                end
                OP_STOP:
                begin
                    unique case (step_next)
                        ST_ONE:  sda_next = 1'b0;
                        ST_TWO:  scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                default:
                begin
                    unique case (step_next)
                        ST_ONE:
                        begin
                            scl_next = 1'b0;
                            if (bit_next < DataBits)
                                sda_next = (op_next == OP_WRITE) ? shift_next[7] : 1'b1;
                            else
                                sda_next = (op_next == OP_WRITE) ? 1'b1 : nack_next;
                        end
                        ST_TWO:  scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
            endcase
        end
    end

    // result word from the updated state
    always_comb
    begin
        res.scl_out  = scl_next;
        res.sda_out  = sda_next;
        res.busy_res = (step_next != ST_IDLE);
        res.done_res = done;
        res.rx_byte  = rx_next;
        res.acked    = ack_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            op_reg    <= OP_NONE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'h00;
            hold_reg  <= '0;
            nack_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rx_reg    <= 8'h00;
            ack_reg   <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            op_reg    <= op_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            nack_reg  <= nack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rx_reg    <= rx_next;
            ack_reg   <= ack_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/i2cm_bus_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_bus_checker
// Watches the command and result queues of the bit-level I2C master, keeps
// its own copy of the tick sequencer, and compares every popped result word
// field by field against the predicted pin trace.
// ----------------------------------------------------------------------------
module i2cm_bus_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           full,
    input  i2cm_pkg::in_word_t                  item,
    input  wire logic                           empty,
    input  wire logic                           pop,
    input  i2cm_pkg::res_word_t                 result,
    input  wire logic                           wr_en,
    input  wire logic [i2cm_pkg::HoldWidth-1:0] wr_data,
    output int                                  fault_count,
    output int                                  trace_depth,
    output logic                                seq_busy
);
    import i2cm_pkg::*;

    // sequencer copy
    logic [HoldWidth-1:0] hold_len_q;
    step_t                step_q;
    logic [3:0]           bit_cnt;
    logic [7:0]           shreg;
    logic [HoldWidth-1:0] hold_cnt;
    op_t                  cur_op;
    logic                 nack_q;
    logic                 scl_q;
    logic                 sda_q;
    logic [7:0]           rx_q;
    logic                 ack_q;

    // predicted pin states, oldest first
    res_word_t pin_trace_q[$];
    res_word_t want;

    // set the pins for the step just entered and reload its hold counter
    function automatic void drive_step();
        case (cur_op)
            OP_START:
                case (step_q)
                    ST_ONE:   sda_q = 1'b1;
                    ST_TWO:   scl_q = 1'b1;
                    ST_THREE: sda_q = 1'b0;
                    default:  scl_q = 1'b0;
                endcase
            OP_STOP:
                case (step_q)
                    ST_ONE:  sda_q = 1'b0;
                    ST_TWO:  scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            default:
                case (step_q)
                    ST_ONE:
                    begin
                        scl_q = 1'b0;
                        if (bit_cnt < DataBits)
                            sda_q = (cur_op == OP_WRITE) ? shreg[7] : 1'b1;
                        else
                            sda_q = (cur_op == OP_WRITE) ? 1'b1 : nack_q;
                    end
                    ST_TWO:  scl_q = 1'b1;
                    default: scl_q = 1'b0;
                endcase
        endcase
        hold_cnt = (hold_len_q == '0) ? 16'd1 : hold_len_q;
    endfunction

    // leave the current step, sampling sda when an scl-high step ends
    function automatic logic close_step(input logic sda_s);
        logic fin;
        fin = 1'b0;
        case (cur_op)
            OP_START:
                if (step_q < ST_FOUR) step_q = step_t'(step_q + 3'd1);
                else fin = 1'b1;
            OP_STOP:
                if (step_q < ST_THREE) step_q = step_t'(step_q + 3'd1);
                else fin = 1'b1;
            OP_WRITE, OP_READ:
                case (step_q)
                    ST_ONE: step_q = ST_TWO;
                    ST_TWO:
                    begin
                        if (bit_cnt < DataBits)
                        begin
                            shreg   = {shreg[6:0], (cur_op == OP_READ) ? sda_s : 1'b0};
                            bit_cnt = bit_cnt + 4'd1;
                            step_q  = ST_ONE;
                        end
                        else
                        begin
                            if (cur_op == OP_WRITE) ack_q = ~sda_s;
                            step_q = ST_THREE;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            default: fin = 1'b1;
        endcase
        if (fin)
        begin
            if (cur_op == OP_READ) rx_q = shreg;
            step_q   = ST_IDLE;
            cur_op   = OP_NONE;
            bit_cnt  = '0;
            hold_cnt = '0;
        end
        else
        begin
            drive_step();
        end
        return fin;
    endfunction

    // advance the sequencer by one tick and give the pin word it shows
    function automatic res_word_t sequencer_tick(input in_word_t w);
        res_word_t r;
        logic      fin;
        fin = 1'b0;
        if (step_q != ST_IDLE)
        begin
            if (hold_cnt <= 16'd1) fin = close_step(w.sda_in);
            else hold_cnt = hold_cnt - 16'd1;
        end
        else if (w.op >= OP_START && w.op <= OP_READ)
        begin
            cur_op  = op_t'(w.op);
            shreg   = (w.op == OP_WRITE) ? w.tx_byte : 8'h00;
            nack_q  = w.send_nack;
            bit_cnt = '0;
            step_q  = ST_ONE;
            drive_step();
        end
        r.scl_out  = scl_q;
        r.sda_out  = sda_q;
        r.busy_res = (step_q != ST_IDLE);
        r.done_res = fin;
        r.rx_byte  = rx_q;
        r.acked    = ack_q;
        return r;
    endfunction

    function automatic void check_field(input string nm, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", nm, exp_v, got_v);
            fault_count++;
        end
    endfunction

    // track both queues at each edge, pops before pushes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_len_q  = HoldReset;
            step_q      = ST_IDLE;
            bit_cnt     = '0;
            shreg       = '0;
            hold_cnt    = '0;
            cur_op      = OP_NONE;
            nack_q      = 1'b0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            rx_q        = '0;
            ack_q       = 1'b0;
            fault_count = 0;
            pin_trace_q.delete();
        end
        else
        begin
            if (wr_en) hold_len_q = wr_data;
            if (pop && !empty)
            begin
                if (pin_trace_q.size() == 0)
                begin
                    $error("result word popped with nothing predicted");
                    fault_count++;
                end
                else
                begin
                    want = pin_trace_q.pop_front();
                    check_field("scl_out", want.scl_out, result.scl_out);
                    check_field("sda_out", want.sda_out, result.sda_out);
                    check_field("busy_res", want.busy_res, result.busy_res);
                    check_field("done_res", want.done_res, result.done_res);
                    check_field("rx_byte", want.rx_byte, result.rx_byte);
                    check_field("acked", want.acked, result.acked);
                end
            end
            if (push && !full) pin_trace_q.push_back(sequencer_tick(item));
        end
        trace_depth = pin_trace_q.size();
        seq_busy    = (step_q != ST_IDLE);
    end

endmodule

// ===== tb/tb_i2c_bit_level_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Drives tick words into the bit-level I2C master: directed commands at the
// reset, unit and zero hold lengths, then start/byte/stop transfers, some
// incomplete, with random content and noise under several idling patterns.
// Checking is done by the bus checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;
    import i2cm_pkg::*;

    localparam longint LimitNs = 64'd20_000_000;

    // how the ticks after a command are filled
    typedef enum {PAD_QUIET, PAD_NOISE, PAD_CMDS, PAD_SDA_LOW, PAD_SDA_HIGH} pad_t;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 push    = 1'b0;
    logic                 pop     = 1'b0;
    logic                 wr_en   = 1'b0;
    logic [HoldWidth-1:0] wr_data = '0;
    in_word_t             item    = '0;
    logic                 full;
    logic                 empty;
    res_word_t            result;

    int   fault_count;
    int   trace_depth;
    logic seq_busy;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int long_stall_req  = 0;
    int hold_eff        = HoldReset;
    int words_sent      = 0;

    i2c_bit_level_master dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    i2cm_bus_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .fault_count (fault_count),
        .trace_depth (trace_depth),
        .seq_busy    (seq_busy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LimitNs);
        $display("tb_i2c_bit_level_master: done, errors");
        $finish;
    end

    // result side: random stalls plus a long hold-off on request
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_stall_req != 0)
            begin
                stall_left     = long_stall_req;
                long_stall_req = 0;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic in_word_t make_word(input logic [2:0] op, input logic [7:0] tx,
                                           input logic nack, input logic sda);
        in_word_t w;
        w.op        = op;
        w.tx_byte   = tx;
        w.send_nack = nack;
        w.sda_in    = sda;
        return w;
    endfunction

    // random word, op codes above read included now and then
    function automatic in_word_t noise_word();
        int       r;
        in_word_t w;
        r = $urandom_range(0, 9);
        w = make_word(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        if (r >= 4 && r <= 8) w.op = 3'($urandom_range(1, 4));
        else if (r == 9) w.op = 3'($urandom_range(5, 7));
        return w;
    endfunction

    // offer one word, holding push until it is taken
    task automatic offer_word(input in_word_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
        words_sent++;
    endtask

    // stop sending and wait for every predicted word to come back
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (trace_depth != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hold(input logic [HoldWidth-1:0] v);
        settle();
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en   <= 1'b0;
        hold_eff = (v == '0) ? 1 : v;
    endtask

    // one command plus exactly the ticks it takes, so the next word lands idle
    task automatic run_command(input in_word_t w, input pad_t pad_kind);
        int       ticks;
        in_word_t p;
        case (w.op)
            OP_START:          ticks = 4;
            OP_STOP:           ticks = 3;
            OP_WRITE, OP_READ: ticks = 19;
            default:           ticks = 0;
        endcase
        offer_word(w);
        repeat (ticks * hold_eff)
        begin
            p = make_word(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            case (pad_kind)
                PAD_NOISE:    p = noise_word();
                PAD_CMDS:     p.op = 3'($urandom_range(1, 4));
                PAD_SDA_LOW:  p.sda_in = 1'b0;
                PAD_SDA_HIGH: p.sda_in = 1'b1;
                default:      ;
            endcase
            offer_word(p);
        end
    endtask

    // start, a few bytes, stop; now and then a piece missing or stray words
    task automatic run_transfer();
        int       nbytes;
        in_word_t w;
        nbytes = $urandom_range(1, 4);
        if ($urandom_range(0, 9) != 0)
            run_command(make_word(OP_START, 8'h00, 1'b0, 1'b1), PAD_NOISE);
        repeat (nbytes)
        begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) offer_word(noise_word());
            w    = noise_word();
            w.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            run_command(w, $urandom_range(0, 1) ? PAD_NOISE : PAD_QUIET);
        end
        if ($urandom_range(0, 9) != 0)
            run_command(make_word(OP_STOP, 8'h00, 1'b0, 1'b1), PAD_NOISE);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct,
                                input logic [HoldWidth-1:0] hold, input int n_words);
        write_hold(hold);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        words_sent      = 0;
        while (words_sent < n_words)
        begin
            if ($urandom_range(0, 4) != 0) run_transfer();
            else repeat (10) offer_word(noise_word());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset hold length, shortened mid-step so only the first step pays for it
        offer_word(make_word(OP_START, 8'h00, 1'b0, 1'b0));
        repeat (int'(HoldReset) - 1)
            offer_word(make_word(OP_NONE, 8'h00, 1'b0, 1'($urandom_range(0, 1))));
        write_hold(16'd1);
        repeat (4) offer_word(make_word(OP_NONE, 8'h00, 1'b0, 1'b1));

        // zero hold behaves as one
        write_hold('0);
        offer_word(make_word(3'd7, 8'hFF, 1'b1, 1'b1));
        offer_word(make_word(3'd5, 8'h00, 1'b0, 1'b0));
        offer_word(make_word(3'd6, 8'hAA, 1'b1, 1'b0));
        // commands during the sequence and on its last tick are dropped
        run_command(make_word(OP_STOP, 8'h00, 1'b0, 1'b1), PAD_CMDS);
        run_command(make_word(OP_START, 8'h00, 1'b0, 1'b1), PAD_CMDS);
        run_command(make_word(OP_WRITE, 8'h80, 1'b0, 1'b1), PAD_SDA_LOW);
        run_command(make_word(OP_WRITE, 8'h7F, 1'b1, 1'b0), PAD_SDA_HIGH);
        run_command(make_word(OP_READ, 8'h00, 1'b0, 1'b1), PAD_SDA_HIGH);
        run_command(make_word(OP_READ, 8'hFF, 1'b1, 1'b0), PAD_SDA_LOW);
        run_command(make_word(OP_WRITE, 8'hFF, 1'b0, 1'b0), PAD_QUIET);
        run_command(make_word(OP_WRITE, 8'h00, 1'b1, 1'b1), PAD_QUIET);
        // repeated start with scl low
        run_command(make_word(OP_START, 8'h00, 1'b0, 1'b0), PAD_QUIET);
        run_command(make_word(OP_READ, 8'h5A, 1'b0, 1'b0), PAD_QUIET);
        run_command(make_word(OP_STOP, 8'h00, 1'b0, 1'b0), PAD_QUIET);

        // result side holds off while words keep coming, so the queues fill
        settle();
        long_stall_req = 500;
        repeat (80) offer_word(noise_word());

        random_phase(0, 0, 16'd1, 70);
        random_phase(61, 0, 16'd2, 70);
        random_phase(0, 61, 16'd1, 70);
        random_phase(38, 38, 16'd2, 70);

        settle();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && trace_depth == 0)
            $display("tb_i2c_bit_level_master: done, clean");
        else
            $display("tb_i2c_bit_level_master: done, errors");
        $finish;
    end

endmodule
